// ===== hdl/ssm_pkg.sv =====
// Package: shared constants, types and helpers for the star segment pixel mirror.
`default_nettype none
package ssm_pkg;
  localparam int PIXEL_BITS  = 16;
  localparam int FIELD_BITS  = 16;
  localparam int SEGMENTS    = 7;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_HIGH_W  = 48;
  localparam int CFG_INDEX_W = 2;
  localparam int LEN_W       = PIXEL_BITS + 1;
  localparam int NUM_W       = PIXEL_BITS + 2;
  localparam int PROD_W      = LEN_W + NUM_W;
  localparam int DVD_W       = PROD_W;
  localparam int DVS_W       = PIXEL_BITS + 1;
  localparam int UNIT_LAT    = DVD_W + 3;
  localparam int TOTAL_LAT   = DVD_W + 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;
  localparam int SEG_W       = 3;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [SEG_W-1:0] seg_idx_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_LOW  = 2'd0,
    REG_START_HIGH = 2'd1,
    REG_END_LOW    = 2'd2,
    REG_END_HIGH   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    pix_t                     start;
    logic signed [LEN_W-1:0]  len;
    logic signed [NUM_W-1:0]  num;
    logic signed [LEN_W-1:0]  den;
  } mirror_job_t;

  typedef struct packed {
    logic flip_ok;
    logic rot_req;
  } mirror_flags_t;

  typedef struct packed {
    mirror_flags_t flags;
    mirror_job_t   flip;
    mirror_job_t   rot;
  } queue_entry_t;

  // x below 28
  function automatic seg_idx_t mod7(input logic [4:0] x);
    logic [4:0] v;
    v = x;
    for (int i = 0; i < 3; i++) begin
      if (v >= 5'(SEGMENTS)) v = v - 5'(SEGMENTS);
    end
    return v[SEG_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/ssm_front.sv =====
// Front end: config registers, segment match and mirror job setup.
`default_nettype none
module ssm_front import ssm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   accept,
  input  wire logic [PIXEL_BITS-1:0]  in_pixel,
  input  wire logic                   in_flip_requested,
  input  wire logic [7:0]             in_emitter_id,
  input  wire logic                   in_rotate_requested,
  input  wire logic                   cfg_wr,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output      logic                   entry_vld,
  output      queue_entry_t           entry
);
  logic [CFG_DATA_W-1:0] start_lo_r, end_lo_r;
  logic [CFG_HIGH_W-1:0] start_hi_r, end_hi_r;
  logic                  vld_r;
  queue_entry_t          entry_r, entry_nxt;

  function automatic pix_t seg_field(input logic [CFG_DATA_W-1:0] lo,
                                     input logic [CFG_HIGH_W-1:0] hi,
                                     input int s);
    logic [FIELD_BITS-1:0] f;
    if (s < 4) f = lo[FIELD_BITS*s +: FIELD_BITS];
    else       f = hi[FIELD_BITS*(s-4) +: FIELD_BITS];
    return f[PIXEL_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_lo_r <= '0;
      start_hi_r <= '0;
      end_lo_r   <= '0;
      end_hi_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_LOW:  start_lo_r <= cfg_data;
        REG_START_HIGH: start_hi_r <= cfg_data[CFG_HIGH_W-1:0];
        REG_END_LOW:    end_lo_r   <= cfg_data;
        REG_END_HIGH:   end_hi_r   <= cfg_data[CFG_HIGH_W-1:0];
      endcase
    end
  end

  pix_t                    seg_s [SEGMENTS];
  pix_t                    seg_e [SEGMENTS];
  seg_idx_t                p, mf, mr;
  logic signed [NUM_W-1:0] num;
  logic signed [LEN_W-1:0] den;
  logic                    den_zero;
  logic [6:0]              eidx;

  always_comb begin
    for (int s = 0; s < SEGMENTS; s++) begin
      seg_s[s] = seg_field(start_lo_r, start_hi_r, s);
      seg_e[s] = seg_field(end_lo_r, end_hi_r, s);
    end
    p = '0;
    for (int s = 0; s < SEGMENTS; s++) begin
      if (in_pixel >= seg_s[s] && in_pixel <= seg_e[s]) p = SEG_W'(s);
    end
    num      = NUM_W'({2'b00, in_pixel}) - NUM_W'({2'b00, seg_s[p]});
    den      = LEN_W'({1'b0, seg_e[p]}) - LEN_W'({1'b0, seg_s[p]});
    den_zero = (den == '0);
    eidx     = in_emitter_id[7:1];
    mf       = mod7(5'({1'b0, eidx[2:0], 1'b0}) + 5'd11 - 5'({2'b00, p}));
    mr       = mod7(5'({2'b00, p}) + 5'd4);

    entry_nxt.flags.flip_ok = in_flip_requested && (eidx < 7'(SEGMENTS));
    entry_nxt.flags.rot_req = in_rotate_requested;
    entry_nxt.flip.start = seg_s[mf];
    entry_nxt.flip.len   = LEN_W'({1'b0, seg_e[mf]}) - LEN_W'({1'b0, seg_s[mf]});
    entry_nxt.flip.num   = den_zero ? NUM_W'(1) : (NUM_W'(den) - num);
    entry_nxt.flip.den   = den_zero ? LEN_W'(1) : den;
    entry_nxt.rot.start  = seg_s[mr];
    entry_nxt.rot.len    = LEN_W'({1'b0, seg_e[mr]}) - LEN_W'({1'b0, seg_s[mr]});
    entry_nxt.rot.num    = den_zero ? '0 : num;
    entry_nxt.rot.den    = den_zero ? LEN_W'(1) : den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) entry_r <= entry_nxt;
  end

  assign entry_vld = vld_r;
  assign entry     = entry_r;
endmodule
`default_nettype wire

// ===== hdl/ssm_queue.sv =====
// Short queue between front end and back end.
`default_nettype none
module ssm_queue import ssm_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire queue_entry_t din,
  output      logic         dout_vld,
  output      queue_entry_t dout,
  output      logic         full
);
  queue_entry_t      mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              pop, do_push;

  assign dout_vld = (cnt_r != '0);
  assign pop      = dout_vld;
  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push  = push && !full;
  assign dout     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)     rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + QCNT_W'(do_push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end
endmodule
`default_nettype wire

// ===== hdl/ssm_mirror_unit.sv =====
// Pipelined scale unit: start + round(len * num / den), restoring divider.
`default_nettype none
module ssm_mirror_unit import ssm_pkg::*; (
  input  wire logic        clk,
  input  wire mirror_job_t job,
  output      pix_t        pix
);
  logic signed [PROD_W-1:0] prod_r;
  logic signed [LEN_W-1:0]  den1_r;
  pix_t                     start1_r;

  always_ff @(posedge clk) begin
    prod_r   <= job.len * job.num;
    den1_r   <= job.den;
    start1_r <= job.start;
  end

  logic [DVS_W-1:0]      rem_r   [DVD_W+1];
  logic [DVD_W-1:0]      dvd_r   [DVD_W+1];
  logic [PIXEL_BITS-1:0] q_r     [DVD_W+1];
  logic [DVS_W-1:0]      dvs_r   [DVD_W+1];
  logic                  neg_r   [DVD_W+1];
  pix_t                  start_r [DVD_W+1];

  logic [PROD_W-1:0] abs_a;
  logic [LEN_W-1:0]  abs_d;

  always_comb begin
    abs_a = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    abs_d = den1_r[LEN_W-1] ? LEN_W'(-den1_r) : LEN_W'(den1_r);
  end

  always_ff @(posedge clk) begin
    rem_r[0]   <= '0;
    dvd_r[0]   <= (DVD_W'(abs_a) << 1) + DVD_W'(abs_d);
    q_r[0]     <= '0;
    dvs_r[0]   <= {abs_d[PIXEL_BITS-1:0], 1'b0};
    neg_r[0]   <= prod_r[PROD_W-1] ^ den1_r[LEN_W-1];
    start_r[0] <= start1_r;
  end

  for (genvar k = 1; k <= DVD_W; k++) begin : g_div
    logic [DVS_W:0] trial;
    logic           ge;
    always_comb begin
      trial = {rem_r[k-1], dvd_r[k-1][DVD_W-1]};
      ge    = (trial >= {1'b0, dvs_r[k-1]});
    end
    always_ff @(posedge clk) begin
      rem_r[k]   <= ge ? DVS_W'(trial - {1'b0, dvs_r[k-1]}) : trial[DVS_W-1:0];
      dvd_r[k]   <= dvd_r[k-1] << 1;
      q_r[k]     <= {q_r[k-1][PIXEL_BITS-2:0], ge};
      dvs_r[k]   <= dvs_r[k-1];
      neg_r[k]   <= neg_r[k-1];
      start_r[k] <= start_r[k-1];
    end
  end

  pix_t pix_r;
  always_ff @(posedge clk) begin
    pix_r <= start_r[DVD_W] + (neg_r[DVD_W] ? pix_t'(-q_r[DVD_W]) : q_r[DVD_W]);
  end

  assign pix = pix_r;
endmodule
`default_nettype wire

// ===== hdl/ssm_back.sv =====
// Back end: two scale units and the matching control delay line.
`default_nettype none
module ssm_back import ssm_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         entry_vld,
  input  wire queue_entry_t entry,
  output      logic         out_valid,
  output      logic [1:0]   out_mirror_count,
  output      logic         out_flip_valid,
  output      pix_t         out_flip_pixel,
  output      logic         out_rotate_valid,
  output      pix_t         out_rotate_pixel
);
  pix_t          flip_pix, rot_pix;
  logic          vld_r   [UNIT_LAT];
  mirror_flags_t flags_r [UNIT_LAT];

  ssm_mirror_unit u_flip (.clk(clk), .job(entry.flip), .pix(flip_pix));
  ssm_mirror_unit u_rot  (.clk(clk), .job(entry.rot),  .pix(rot_pix));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < UNIT_LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= entry_vld;
      for (int i = 1; i < UNIT_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    flags_r[0] <= entry.flags;
    for (int i = 1; i < UNIT_LAT; i++) flags_r[i] <= flags_r[i-1];
  end

  logic fv, rv;
  always_comb begin
    fv               = vld_r[UNIT_LAT-1] && flags_r[UNIT_LAT-1].flip_ok;
    rv               = vld_r[UNIT_LAT-1] && flags_r[UNIT_LAT-1].rot_req;
    out_valid        = vld_r[UNIT_LAT-1];
    out_flip_valid   = fv;
    out_rotate_valid = rv;
    out_mirror_count = 2'(fv) + 2'(rv);
    out_flip_pixel   = fv ? flip_pix : '0;
    out_rotate_pixel = rv ? rot_pix : '0;
  end
endmodule
`default_nettype wire

// ===== hdl/star_segment_pixel_mirror_core.sv =====
// Top level of the star segment pixel mirror.
// An accepted transaction passes the front-end register, the queue, the product register, the divider
// setup register, the bit-per-stage restoring divider (35 stages) and the output register to out_valid.
// Throughput: one transaction per cycle; busy only rises if the queue fills, which a
// non-stalling result side never lets happen.
// Reset: synchronous active-low rst_n clears config registers to 0 and drops all valids.
`default_nettype none
module star_segment_pixel_mirror_core import ssm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_start,
  output      logic                   busy,
  input  wire logic [PIXEL_BITS-1:0]  in_pixel,
  input  wire logic                   in_flip_requested,
  input  wire logic [7:0]             in_emitter_id,
  input  wire logic                   in_rotate_requested,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output      logic                   out_valid,
  output      logic [1:0]             out_mirror_count,
  output      logic                   out_flip_valid,
  output      logic [PIXEL_BITS-1:0]  out_flip_pixel,
  output      logic                   out_rotate_valid,
  output      logic [PIXEL_BITS-1:0]  out_rotate_pixel
);
  logic         full, front_vld, q_vld;
  queue_entry_t front_entry, q_entry;

  assign busy      = full;
  assign cfg_ready = 1'b1;

  ssm_front u_front (
    .clk(clk), .rst_n(rst_n), .accept(in_start && !busy),
    .in_pixel(in_pixel), .in_flip_requested(in_flip_requested),
    .in_emitter_id(in_emitter_id), .in_rotate_requested(in_rotate_requested),
    .cfg_wr(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .entry_vld(front_vld), .entry(front_entry)
  );

  ssm_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(front_vld), .din(front_entry),
    .dout_vld(q_vld), .dout(q_entry), .full(full)
  );

  ssm_back u_back (
    .clk(clk), .rst_n(rst_n), .entry_vld(q_vld), .entry(q_entry),
    .out_valid(out_valid), .out_mirror_count(out_mirror_count),
    .out_flip_valid(out_flip_valid), .out_flip_pixel(out_flip_pixel),
    .out_rotate_valid(out_rotate_valid), .out_rotate_pixel(out_rotate_pixel)
  );
endmodule
`default_nettype wire

// ===== hdl/ssm_checker.sv =====
// Port-level checker for the star segment pixel mirror, bound to the top level.
`default_nettype none
module ssm_checker import ssm_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_start,
  input wire logic                  busy,
  input wire logic                  out_valid,
  input wire logic [1:0]            out_mirror_count,
  input wire logic                  out_flip_valid,
  input wire logic [PIXEL_BITS-1:0] out_flip_pixel,
  input wire logic                  out_rotate_valid,
  input wire logic [PIXEL_BITS-1:0] out_rotate_pixel
);
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_start && !busy) |-> ##TOTAL_LAT out_valid)
    else $error("transaction result missing");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_mirror_count == 2'(out_flip_valid) + 2'(out_rotate_valid))
    else $error("mirror count mismatch");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> (!out_flip_valid && !out_rotate_valid))
    else $error("mirror flags without strobe");

  a_zero_pix: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_flip_valid |-> out_flip_pixel == '0) and
    (!out_rotate_valid |-> out_rotate_pixel == '0))
    else $error("pixel not zero when absent");
endmodule

bind star_segment_pixel_mirror_core ssm_checker u_ssm_checker (
  .clk(clk), .rst_n(rst_n), .in_start(in_start), .busy(busy),
  .out_valid(out_valid), .out_mirror_count(out_mirror_count),
  .out_flip_valid(out_flip_valid), .out_flip_pixel(out_flip_pixel),
  .out_rotate_valid(out_rotate_valid), .out_rotate_pixel(out_rotate_pixel)
);
`default_nettype wire

// ===== tb/sv/star_segment_pixel_mirror_checker.sv =====
// Checker: predicts star segment mirror results from accepted transactions and compares them.
module star_segment_pixel_mirror_checker import ssm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_start,
  input  logic                   busy,
  input  logic [PIXEL_BITS-1:0]  in_pixel,
  input  logic                   in_flip_requested,
  input  logic [7:0]             in_emitter_id,
  input  logic                   in_rotate_requested,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   out_valid,
  input  logic [1:0]             out_mirror_count,
  input  logic                   out_flip_valid,
  input  logic [PIXEL_BITS-1:0]  out_flip_pixel,
  input  logic                   out_rotate_valid,
  input  logic [PIXEL_BITS-1:0]  out_rotate_pixel,
  output int                     fail_count,
  output int                     pending
);
  typedef struct packed {
    logic [1:0]  count;
    logic        fv;
    logic [15:0] fp;
    logic        rv;
    logic [15:0] rp;
  } mirror_t;

  logic [63:0] start_lo, start_hi, end_lo, end_hi;
  mirror_t mirror_q[$];

  function automatic longint seg_start(int s);
    return (s < 4) ? longint'(start_lo[16*s +: 16]) : longint'(start_hi[16*(s-4) +: 16]);
  endfunction

  function automatic longint seg_end(int s);
    return (s < 4) ? longint'(end_lo[16*s +: 16]) : longint'(end_hi[16*(s-4) +: 16]);
  endfunction

  function automatic longint round_div(longint a, longint d);
    longint ua, ud, q;
    ua = (a < 0) ? -a : a;
    ud = (d < 0) ? -d : d;
    q = (2 * ua + ud) / (2 * ud);
    return ((a < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic logic [15:0] point_on(int m, longint num, longint den);
    longint s, len, off;
    s = seg_start(m);
    len = seg_end(m) - s;
    off = (den == 0) ? 0 : round_div(len * num, den);
    return 16'(s + off);
  endfunction

  function automatic mirror_t predict_mirror(logic [15:0] pix, logic fr, logic [7:0] eid,
                                              logic rr);
    mirror_t r;
    int p, e;
    longint num, den;
    r = '0;
    p = 0;
    e = eid / 2;
    for (int s = 0; s < SEGMENTS; s++)
      if (pix >= seg_start(s) && pix <= seg_end(s)) p = s;
    num = longint'(pix) - seg_start(p);
    den = seg_end(p) - seg_start(p);
    if (den == 0) num = 0;
    if (fr && e < SEGMENTS) begin
      r.fv = 1'b1;
      r.fp = (den == 0) ? point_on((2*e + 11 - p) % 7, 1, 1)
                        : point_on((2*e + 11 - p) % 7, den - num, den);
      r.count++;
    end
    if (rr) begin
      r.rv = 1'b1;
      r.rp = point_on((p + 4) % 7, num, den);
      r.count++;
    end
    return r;
  endfunction

  assign pending = mirror_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    mirror_t exp_m, got;
    if (!rst_n) begin
      start_lo <= '0; start_hi <= '0; end_lo <= '0; end_hi <= '0;
    end else begin
      if (in_start && !busy)
        mirror_q.push_back(predict_mirror(in_pixel, in_flip_requested, in_emitter_id,
                                          in_rotate_requested));
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_START_LOW:  start_lo <= cfg_data;
          REG_START_HIGH: start_hi <= {16'h0, cfg_data[47:0]};
          REG_END_LOW:    end_lo <= cfg_data;
          REG_END_HIGH:   end_hi <= {16'h0, cfg_data[47:0]};
        endcase
      end
      if (out_valid) begin
        got = '{out_mirror_count, out_flip_valid, out_flip_pixel, out_rotate_valid,
                out_rotate_pixel};
        if (mirror_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction %p", got);
        end else begin
          exp_m = mirror_q.pop_front();
          if (got !== exp_m) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", exp_m, got);
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/star_segment_pixel_mirror_core_tb.sv =====
// Testbench top: drives transactions and configuration into the star segment mirror core.
module star_segment_pixel_mirror_core_tb;
  import ssm_pkg::*;

  logic clk, rst_n;
  logic in_start, busy, in_flip_requested, in_rotate_requested;
  logic [PIXEL_BITS-1:0] in_pixel;
  logic [7:0] in_emitter_id;
  logic cfg_valid, cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic out_valid, out_flip_valid, out_rotate_valid;
  logic [1:0] out_mirror_count;
  logic [PIXEL_BITS-1:0] out_flip_pixel, out_rotate_pixel;
  int fail_count, pending;
  logic [15:0] seg_s[7], seg_e[7];

  star_segment_pixel_mirror_core u_dut (.*);
  star_segment_pixel_mirror_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  // start stays high between back-to-back transactions; it drops only for a real gap
  task automatic gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n > 0) begin
      in_start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send(logic [15:0] pix, logic fr, logic [7:0] eid, logic rr);
    in_start <= 1'b1;
    in_pixel <= pix;
    in_flip_requested <= fr;
    in_emitter_id <= eid;
    in_rotate_requested <= rr;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    in_start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TOTAL_LAT + 5) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_segments();
    write_reg(REG_START_LOW, {seg_s[3], seg_s[2], seg_s[1], seg_s[0]});
    write_reg(REG_START_HIGH, {16'($urandom_range(0, 65535)), seg_s[6], seg_s[5], seg_s[4]});
    write_reg(REG_END_LOW, {seg_e[3], seg_e[2], seg_e[1], seg_e[0]});
    write_reg(REG_END_HIGH, {16'($urandom_range(0, 65535)), seg_e[6], seg_e[5], seg_e[4]});
    cfg_valid <= 1'b0;
  endtask

  // mode 0: tiled star, 1: random, 2: reversed/zero-length, 3: extremes
  task automatic pick_segments(int mode);
    for (int s = 0; s < 7; s++) begin
      case (mode)
        0: begin
          seg_s[s] = 16'(s * 40);
          seg_e[s] = 16'(s * 40 + 39 - (s == 3 ? 39 : 0));
        end
        1: begin seg_s[s] = 16'($urandom); seg_e[s] = 16'($urandom); end
        2: begin
          seg_s[s] = 16'($urandom_range(0, 2000));
          seg_e[s] = (s % 3 == 0) ? seg_s[s] : 16'(seg_s[s] - $urandom_range(1, 300));
        end
        default: begin seg_s[s] = (s % 2) ? 16'hFFFF : 16'h0000; seg_e[s] = 16'hFFFF; end
      endcase
    end
  endtask

  task automatic random_item();
    logic [15:0] pix;
    int s;
    s = $urandom_range(0, 6);
    case ($urandom_range(0, 3))
      0: pix = 16'($urandom);
      1: pix = seg_s[s];
      2: pix = seg_e[s];
      default: pix = (seg_s[s] <= seg_e[s]) ? 16'($urandom_range(seg_s[s], seg_e[s]))
                                            : seg_s[s];
    endcase
    send(pix, 1'($urandom_range(0, 1)),
         ($urandom_range(0, 4) == 0) ? 8'($urandom_range(14, 255)) : 8'($urandom_range(0, 13)),
         1'($urandom_range(0, 1)));
    gap();
  endtask

  initial begin
    rst_n = 0;
    in_start = 0; in_pixel = 0; in_flip_requested = 0; in_emitter_id = 0;
    in_rotate_requested = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    repeat (6) @(negedge clk);
    rst_n = 1;
    // reset-state registers: all segments zero-length at pixel 0
    send(16'h0000, 1, 8'd0, 1);
    send(16'hFFFF, 1, 8'd13, 1);
    drain();
    pick_segments(0);
    load_segments();
    send(16'h0000, 1, 8'd0, 1);
    send(16'd120, 1, 8'd1, 0);
    send(16'd20, 0, 8'd5, 1);
    send(16'd279, 1, 8'd12, 1);
    send(16'hFFFF, 1, 8'd14, 1);
    send(16'hFFFF, 1, 8'd255, 0);
    send(16'h5AA5, 0, 8'hAA, 0);
    send(16'hA55A, 1, 8'h55, 1);
    for (int e = 0; e < 14; e += 2) send(16'(45 + e), 1, e[7:0], 1);
    drain();
    for (int ph = 0; ph < 9; ph++) begin
      pick_segments(ph % 4);
      load_segments();
      for (int k = 0; k < 48; k++) random_item();
      drain();
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
